// ===== rtl/modular_inverse_assert.svh =====
// Assertion macros for the checker file of the modular inverse block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MODULAR_INVERSE_ASSERT_SVH
`define MODULAR_INVERSE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/modinv_pkg.sv =====
`timescale 1ns / 1ps

package modinv_pkg;

  // Extra bits carried by the Bezout coefficients and the quotient product
  // above the word width, so that every value the algorithm produces fits.
  localparam int unsigned COEF_GUARD_BITS = 2;

  // Smallest and largest supported word width.
  localparam int unsigned MIN_WORD_BITS = 8;
  localparam int unsigned MAX_WORD_BITS = 64;

endpackage

// ===== rtl/modular_inverse.sv =====
`timescale 1ns / 1ps
// Each Euclid round is one pass of a shared one-bit-per-cycle restoring divider,
// which also folds the input value into range first. A new transaction is taken
// only once the sequencer has handed the previous result to the output register.
// Reset: rst is synchronous and active high; it returns the sequencer to idle and
// drops out_valid.

module modular_inverse
  import modinv_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] value_in,
  input  logic        [WORD_BITS-2:0] modulus_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] inverse_out,
  output logic                        no_inverse
);

  localparam int unsigned CW       = WORD_BITS + COEF_GUARD_BITS;
  localparam int unsigned CNT_BITS = $clog2(WORD_BITS);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(WORD_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  state_t                state;
  logic [CNT_BITS-1:0]   cnt;
  logic [WORD_BITS-1:0]  dq;      // dividend, shifted out as quotient bits come in
  logic [WORD_BITS-2:0]  rem;     // partial remainder
  logic [WORD_BITS-2:0]  dv;      // divisor
  logic [WORD_BITS-2:0]  m;
  logic [WORD_BITS-2:0]  r;
  logic [WORD_BITS-2:0]  nr;
  logic signed [CW-1:0]  s;
  logic signed [CW-1:0]  ns;
  logic signed [CW-1:0]  acc;     // quotient times ns, built bit by bit
  logic                  neg;

  // Shared divider step: shift in the next dividend bit and try the subtract.
  logic [WORD_BITS-1:0]  rem_shift;
  logic [WORD_BITS-1:0]  rem_diff;
  logic                  q_bit;
  logic [WORD_BITS-2:0]  rem_next;
  logic signed [CW-1:0]  acc_next;

  assign rem_shift = {rem, dq[WORD_BITS-1]};
  assign rem_diff  = rem_shift - {1'b0, dv};
  assign q_bit     = (rem_shift >= {1'b0, dv});
  assign rem_next  = q_bit ? rem_diff[WORD_BITS-2:0] : rem_shift[WORD_BITS-2:0];
  assign acc_next  = {acc[CW-2:0], 1'b0} + (q_bit ? ns : '0);

  // Input fold helpers and the final coefficient fix-up.
  logic [WORD_BITS-1:0]  value_mag;
  logic [WORD_BITS-2:0]  folded;
  logic signed [CW-1:0]  s_fixed;

  assign value_mag = (~value_in) + WORD_BITS'(1);
  assign folded    = (neg && (rem_next != '0)) ? (m - rem_next) : rem_next;
  assign s_fixed   = s[CW-1] ? (s + CW'(m)) : s;

  assign in_stall = (state != ST_IDLE);

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A taken result leaves the output register, unless a new one replaces it.
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            m   <= modulus_in;
            neg <= value_in[WORD_BITS-1];
            dq  <= value_in[WORD_BITS-1] ? value_mag : value_in;
            dv  <= modulus_in;
            rem <= '0;
            cnt <= '0;
            if (modulus_in == '0) begin
              // No inverse exists for a zero modulus; a zero gcd reports it.
              r     <= '0;
              state <= ST_FINISH;
            end else begin
              state <= ST_FOLD;
            end
          end
        end
        ST_FOLD: begin
          rem <= rem_next;
          dq  <= {dq[WORD_BITS-2:0], q_bit};
          cnt <= cnt + CNT_BITS'(1);
          if (cnt == LAST_STEP) begin
            r     <= m;
            nr    <= folded;
            s     <= '0;
            ns    <= CW'(1);
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (nr == '0) begin
            state <= ST_FINISH;
          end else begin
            dq    <= {1'b0, r};
            dv    <= nr;
            rem   <= '0;
            acc   <= '0;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          dq  <= {dq[WORD_BITS-2:0], q_bit};
          acc <= acc_next;
          cnt <= cnt + CNT_BITS'(1);
          if (cnt == LAST_STEP) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          ns    <= s - acc;
          s     <= ns;
          nr    <= rem;
          r     <= nr;
          state <= ST_CHECK;
        end
        ST_FINISH: begin
          // Wait for the output register to be free.
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (r != (WORD_BITS-1)'(1)) begin
              inverse_out <= '1;
              no_inverse  <= 1'b1;
            end else if (m == (WORD_BITS-1)'(1)) begin
              inverse_out <= '0;
              no_inverse  <= 1'b0;
            end else begin
              inverse_out <= s_fixed[WORD_BITS-1:0];
              no_inverse  <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/modinv_check.sv =====
`timescale 1ns / 1ps
`include "modular_inverse_assert.svh"

module modinv_check
  import modinv_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic signed [WORD_BITS-1:0] value_in,
  input logic        [WORD_BITS-2:0] modulus_in,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [WORD_BITS-1:0] inverse_out,
  input logic                        no_inverse
);

  // A stalled result stays offered.
  `MI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // A missing inverse is always reported as all ones.
  `MI_ASSERT_IMPL(a_none_ones, out_valid && no_inverse, inverse_out == '1, "bad no-inverse code")

  // A real inverse is never negative.
  `MI_ASSERT_IMPL(a_inv_pos, out_valid && !no_inverse, !inverse_out[WORD_BITS-1], "negative inverse")

  // The block is busy in the cycle after it takes a transaction.
  `MI_ASSERT_NEXT(a_busy, in_valid && !in_stall && modulus_in != '0, in_stall, "not busy after accept")

endmodule

bind modular_inverse modinv_check #(.WORD_BITS(WORD_BITS)) u_check (.*);

// ===== tb/tb_modular_inverse.sv =====
`timescale 1ns / 1ps

module tb_modular_inverse;

  localparam int unsigned WORD_BITS = 32;
  // Worst case is about 46 Euclid rounds of one full-width division each.
  localparam int unsigned DRAIN_CYCLES = (WORD_BITS + 2) * 48 + 2;
  localparam int unsigned LONG_HOLD_CYCLES = 3 * DRAIN_CYCLES;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned PHASE_ITEMS = 65;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] inverse;
    logic                        no_inv;
  } inverse_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [WORD_BITS-1:0] value_in = '0;
  logic        [WORD_BITS-2:0] modulus_in = 1;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [WORD_BITS-1:0] inverse_out;
  logic                        no_inverse;

  // Inverses still owed by the block, oldest first.
  inverse_result_t pending_inverses[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // The test side toggles this to ask the receiver for one long hold-off.
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int unsigned hold_left = 0;

  modular_inverse #(
    .WORD_BITS(WORD_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value_in   (value_in),
    .modulus_in (modulus_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .inverse_out(inverse_out),
    .no_inverse (no_inverse)
  );

  always #5 clk = ~clk;

  // Expected inverse by the extended Euclidean algorithm on 64-bit values.
  function automatic inverse_result_t compute_mod_inverse(
      input logic signed [WORD_BITS-1:0] value,
      input logic        [WORD_BITS-2:0] modulus);
    inverse_result_t res;
    logic [63:0] m, mag, rem, a, r, nr, q, t;
    longint      s, ns, ts;
    m = 64'(modulus);
    // Fold a negative value through its magnitude, which never overflows.
    if (value[WORD_BITS-1]) begin
      mag = {{(64-WORD_BITS){1'b0}}, ~value} + 64'd1;
      rem = mag % m;
      a = (rem == 0) ? 64'd0 : m - rem;
    end else begin
      a = {{(64-WORD_BITS){1'b0}}, value} % m;
    end
    r = m;
    nr = a;
    s = 0;
    ns = 1;
    while (nr != 0) begin
      q = r / nr;
      ts = ns;
      ns = s - longint'(q) * ns;
      s = ts;
      t = nr;
      nr = r - q * nr;
      r = t;
    end
    if (r > 1) begin
      res.inverse = '1;
      res.no_inv = 1'b1;
    end else begin
      if (m == 1) s = 0;
      else if (s < 0) s = s + longint'(m);
      res.inverse = s[WORD_BITS-1:0];
      res.no_inv = 1'b0;
    end
    return res;
  endfunction

  task automatic record_failure(input string detail);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("MISMATCH: %s", detail);
  endtask

  // Offers one request, after a random idle gap, and holds it until accepted.
  task automatic send_request(input logic signed [WORD_BITS-1:0] value,
                              input logic [WORD_BITS-2:0] modulus);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    value_in <= value;
    modulus_in <= modulus;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_inverses.push_back(compute_mod_inverse(value, modulus));
  endtask

  // Mostly random operands, with a share of multiples, extremes and
  // small or power-of-two moduli so that the no-inverse path is common.
  task automatic send_random_item();
    logic        [WORD_BITS-2:0] modulus;
    logic signed [WORD_BITS-1:0] value;
    case ($urandom_range(9))
      0: modulus = (WORD_BITS-1)'($urandom_range(16, 1));
      1: modulus = (WORD_BITS-1)'(32'd1 << $urandom_range(WORD_BITS - 2));
      2: modulus = '1;
      default: begin
        modulus = (WORD_BITS-1)'($urandom);
        if (modulus == 0) modulus = 1;
      end
    endcase
    case ($urandom_range(7))
      0: value = modulus * $urandom_range(4);
      1: value = -(modulus * $urandom_range(4, 1));
      2: value = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: value = $urandom;
    endcase
    send_request(value, modulus);
  endtask

  task automatic send_random_items(input int unsigned count);
    repeat (count) send_random_item();
  endtask

  // Stops offering requests until every owed inverse has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_inverses.size() != 0);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(3, 7);
    send_request(15, 26);
    send_request(0, 1);
    send_request(-5, 1);
    send_request(32'h7FFF_FFFF, 1);
    send_request(0, 13);
    send_request(32'h8000_0000, 31'h7FFF_FFFF);
    send_request(32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_request(32'h8000_0000, 2);
    send_request(32'h8000_0000, 3);
    send_request(-1, 31'h7FFF_FFFF);
    send_request(1, 31'h7FFF_FFFF);
    send_request(-1, 2);
    send_request(12, 4);
    send_request(-12, 6);
    send_request(-7, 10);
    // Consecutive Fibonacci numbers take the most Euclid rounds.
    send_request(1134903170, 1836311903);
    send_request(1836311903, 1134903170);
    send_request(32'h7FFF_FFFF, 31'h4000_0000);
    send_request(6, 31'h4000_0000);
    send_request(-3, 31'h3FFF_FFFF);
  endtask

  task automatic test_random_no_idling();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random_items(PHASE_ITEMS);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 46;
    recv_stall_pct = 0;
    send_random_items(PHASE_ITEMS);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    recv_stall_pct = 46;
    send_random_items(PHASE_ITEMS);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 32;
    recv_stall_pct = 32;
    send_random_items(PHASE_ITEMS);
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the block fills up and has to stall its input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_toggle <= ~hold_toggle;
    send_random_items(8);
    wait_for_results();
  endtask

  // The sender stops until the block is empty, then resumes.
  task automatic test_pause_until_drained();
    send_idle_pct = 20;
    recv_stall_pct = 20;
    send_random_items(6);
    wait_for_results();
    send_random_items(6);
  endtask

  // Receiver: random stalls, or one long hold-off when asked.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest owed inverse.
  always @(posedge clk) begin
    inverse_result_t owed;
    if (!rst && out_valid && !out_stall) begin
      if (pending_inverses.size() == 0) begin
        record_failure($sformatf("unexpected result inverse %0d no_inverse %0b",
                                 inverse_out, no_inverse));
      end else begin
        owed = pending_inverses.pop_front();
        if (inverse_out !== owed.inverse || no_inverse !== owed.no_inv)
          record_failure($sformatf(
              "expected inverse %0d no_inverse %0b, got inverse %0d no_inverse %0b",
              owed.inverse, owed.no_inv, inverse_out, no_inverse));
      end
    end
  end

  // Hard limit on the length of the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_no_idling();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_output_backpressure();
    test_pause_until_drained();
    // Let the last results out and watch for any extra ones.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_inverses.size() != 0)
      record_failure($sformatf("%0d results never arrived", pending_inverses.size()));
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== modular_inverse.f =====
+incdir+rtl
rtl/modinv_pkg.sv
rtl/modular_inverse.sv
rtl/modinv_check.sv
tb/tb_modular_inverse.sv
